// ===== hdl/column_rle_sprite_decoder_unit_assert.svh =====
// Assertion macros for the column RLE sprite decoder.
`ifndef COLUMN_RLE_SPRITE_DECODER_UNIT_ASSERT_SVH
`define COLUMN_RLE_SPRITE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CRSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crsd_pkg.sv =====
// Shared types, codes and constants of the column RLE sprite decoder.
package crsd_pkg;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int ROW_MAX_W       = 12;   // row index width at the largest row count
  localparam int Q_DEPTH         = 2;
  localparam int CFG_DATA_W      = 11;
  localparam int CFG_INDEX_W     = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y      = 2'd2;

  // Column op codes and data byte codes
  localparam logic [7:0] OP_SKIP     = 8'hFF;
  localparam logic [7:0] OP_DECODE   = 8'h80;
  localparam logic [7:0] OP_COPY     = 8'h00;
  localparam logic [7:0] REPEAT_MIN  = 8'd224;
  localparam logic [7:0] REPEAT_BIAS = 8'd223;

  // Result kinds
  localparam logic RK_PIXEL     = 1'b0;
  localparam logic RK_FRAME_END = 1'b1;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       frame_head;
  } in_beat_t;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic [7:0]  pixel_value;
    logic        last;
  } out_beat_t;

  // Work handed from the parser to the pixel writer
  typedef struct packed {
    logic [5:0]           pix_cnt;
    logic [7:0]           pixel;
    logic [10:0]          pos_x;
    logic [ROW_MAX_W-1:0] row;
    logic                 frame_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/crsd_front.sv =====
// Byte parser: walks the column/packet/sequence structure and issues write jobs.
module crsd_front import crsd_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  input  logic [10:0] frame_columns,
  input  logic [9:0]  origin_x,
  input  q_stat_t     q_stat,
  output logic        q_push,
  output job_t        q_job
);

  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int SUM_W = ((ROW_W > 8) ? ROW_W : 8) + 1;
  localparam int XS_W  = ((COL_W > 10) ? COL_W : 10) + 1;
  localparam int EFF_W = (COL_W > 11) ? COL_W : 11;
  localparam logic [SUM_W-1:0] ROW_LIMIT = SUM_W'(MAX_ROWS - 1);
  localparam logic [EFF_W-1:0] COL_LIMIT = EFF_W'(MAX_COLUMNS);

  typedef enum logic [2:0] {
    PH_OP, PH_COUNT, PH_COUNT_ONLY, PH_SEQLEN, PH_DELTA, PH_DATA, PH_REPVAL, PH_DONE
  } phase_t;

  phase_t           phase_r, phase_nxt, phase_cur;
  logic [COL_W-1:0] col_r, col_nxt, col_cur, col_inc;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic [7:0]       pkt_r, pkt_nxt, pkt_cur;
  logic [7:0]       seq_r, seq_nxt, seq_cur;
  logic             dm_r, dm_nxt, dm_cur;
  logic [5:0]       rep_r, rep_nxt, rep_cur;

  logic             accept, fs;
  logic [7:0]       b;
  logic [7:0]       add_amt;
  logic [SUM_W-1:0] row_sum, row_sat;
  logic [XS_W-1:0]  x_sum;
  logic [EFF_W-1:0] eff_cols;
  logic             do_endseq, do_endcol;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign b        = in_data.code_byte;
  assign fs       = in_data.frame_head;

  always_comb begin
    // a frame head restarts the parser before this byte is parsed
    phase_cur = fs ? PH_OP : phase_r;
    col_cur   = fs ? '0 : col_r;
    row_cur   = fs ? '0 : row_r;
    pkt_cur   = fs ? '0 : pkt_r;
    seq_cur   = fs ? '0 : seq_r;
    dm_cur    = fs ? 1'b0 : dm_r;
    rep_cur   = fs ? '0 : rep_r;

    if (frame_columns == '0) begin
      eff_cols = EFF_W'(1);
    end else if (EFF_W'(frame_columns) > COL_LIMIT) begin
      eff_cols = COL_LIMIT;
    end else begin
      eff_cols = EFF_W'(frame_columns);
    end

    phase_nxt = phase_cur;
    col_nxt   = col_cur;
    pkt_nxt   = pkt_cur;
    seq_nxt   = seq_cur;
    dm_nxt    = dm_cur;
    rep_nxt   = rep_cur;
    add_amt   = '0;
    do_endseq = 1'b0;
    do_endcol = 1'b0;

    x_sum = XS_W'(origin_x) + XS_W'(col_cur);
    q_job.pix_cnt   = '0;
    q_job.pixel     = b;
    q_job.pos_x     = x_sum[10:0];
    q_job.row       = ROW_MAX_W'(row_cur);
    q_job.frame_end = 1'b0;

    case (phase_cur)
      PH_OP: begin
        if (b == OP_SKIP) begin
          do_endcol = 1'b1;
        end else if (b inside {OP_DECODE, OP_COPY}) begin
          dm_nxt    = (b == OP_DECODE);
          phase_nxt = PH_COUNT;
        end else begin
          phase_nxt = PH_COUNT_ONLY;
        end
      end
      PH_COUNT: begin
        pkt_nxt   = b;
        phase_nxt = PH_SEQLEN;
      end
      PH_COUNT_ONLY: do_endcol = 1'b1;
      PH_SEQLEN: begin
        seq_nxt   = b;
        pkt_nxt   = pkt_cur - b - 8'd2;
        phase_nxt = PH_DELTA;
      end
      PH_DELTA: begin
        add_amt = b;
        if (seq_cur == '0) begin
          do_endseq = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        seq_nxt = seq_cur - 8'd1;
        if (dm_cur && (b inside {[REPEAT_MIN:8'hFF]})) begin
          rep_nxt   = 6'(b - REPEAT_BIAS);
          phase_nxt = PH_REPVAL;
        end else begin
          q_job.pix_cnt = 6'd1;
          add_amt       = 8'd1;
          do_endseq     = (seq_nxt == '0);
        end
      end
      PH_REPVAL: begin
        seq_nxt       = (seq_cur != '0) ? seq_cur - 8'd1 : seq_cur;
        q_job.pix_cnt = rep_cur;
        add_amt       = 8'(rep_cur);
        rep_nxt       = '0;
        if (seq_nxt == '0) begin
          do_endseq = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DONE: ;
      default: phase_nxt = PH_DONE;
    endcase

    // Advance the row with saturation at the last row
    row_sum = SUM_W'(row_cur) + SUM_W'(add_amt);
    row_sat = (row_sum > ROW_LIMIT) ? ROW_LIMIT : row_sum;
    row_nxt = ROW_W'(row_sat);

    if (do_endseq) begin
      if (pkt_cur != '0) begin
        phase_nxt = PH_SEQLEN;
      end else begin
        do_endcol = 1'b1;
      end
    end

    col_inc = col_cur + COL_W'(1);
    if (do_endcol) begin
      col_nxt = col_inc;
      row_nxt = '0;
      if (EFF_W'(col_inc) >= eff_cols) begin
        q_job.frame_end = 1'b1;
        phase_nxt       = PH_DONE;
      end else begin
        phase_nxt = PH_OP;
      end
    end

    q_push = accept && ((q_job.pix_cnt != '0) || q_job.frame_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OP;
      col_r   <= '0;
      row_r   <= '0;
      pkt_r   <= '0;
      seq_r   <= '0;
      dm_r    <= 1'b0;
      rep_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pkt_r   <= pkt_nxt;
      seq_r   <= seq_nxt;
      dm_r    <= dm_nxt;
      rep_r   <= rep_nxt;
    end
  end

endmodule

// ===== hdl/crsd_queue.sv =====
// Short job queue between the parser and the pixel writer.
module crsd_queue import crsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head_job,
  output q_stat_t stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);

  job_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/crsd_back.sv =====
// Pixel writer: expands one job into pixel beats and the frame-end beat.
module crsd_back import crsd_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  job_t       q_job,
  output logic       q_pop,
  input  logic [9:0] origin_y,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int YS_W  = ((ROW_W > 10) ? ROW_W : 10) + 1;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

  logic             job_v_r, job_v_nxt;
  logic [5:0]       rem_r, rem_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [10:0]      x_r, x_nxt;
  logic [7:0]       pix_r, pix_nxt;
  logic             fe_r, fe_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  logic             emit;
  logic [YS_W-1:0]  y_sum;
  out_beat_t        res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    q_pop = !job_v_r && !q_stat.empty;
    emit  = job_v_r && (!out_valid_r || !out_stall);
    y_sum = YS_W'(origin_y) + YS_W'(row_r);

    if (rem_r != '0) begin
      res.result_kind = RK_PIXEL;
      res.pos_x       = x_r;
      res.pos_y       = y_sum[10:0];
      res.pixel_value = pix_r;
      res.last        = (rem_r == 6'd1) && !fe_r;
    end else begin
      // Frame end sits one column past the last pixel column, at row zero
      res.result_kind = RK_FRAME_END;
      res.pos_x       = x_r + 11'd1;
      res.pos_y       = 11'(origin_y);
      res.pixel_value = '0;
      res.last        = 1'b1;
    end

    job_v_nxt     = job_v_r;
    rem_nxt       = rem_r;
    row_nxt       = row_r;
    x_nxt         = x_r;
    pix_nxt       = pix_r;
    fe_nxt        = fe_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (q_pop) begin
      job_v_nxt = 1'b1;
      rem_nxt   = q_job.pix_cnt;
      row_nxt   = ROW_W'(q_job.row);
      x_nxt     = q_job.pos_x;
      pix_nxt   = q_job.pixel;
      fe_nxt    = q_job.frame_end;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      if (rem_r != '0) begin
        rem_nxt = rem_r - 6'd1;
        row_nxt = (row_r == ROW_LAST) ? row_r : row_r + ROW_W'(1);
      end
      if (res.last) begin
        job_v_nxt = 1'b0;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      job_v_r     <= job_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    row_r      <= row_nxt;
    x_r        <= x_nxt;
    pix_r      <= pix_nxt;
    fe_r       <= fe_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/column_rle_sprite_decoder_unit.sv =====
// Top level of the column RLE sprite decoder: parser, job queue and pixel writer.
// Path: a byte's results pass the job queue, the writer's job registers and the output register.
// Throughput: the pixel writer loads a job, then issues one beat per cycle while out_stall is low,
// and it takes no new job until the last beat of the current one has been issued.
// Reset (rst_n low, synchronous): parser expects a column op, queue and output empty,
// frame_columns = 1, origin_x = origin_y = 0; no clearing pass.
module column_rle_sprite_decoder_unit import crsd_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_beat_t              out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "column_rle_sprite_decoder_unit_assert.svh"

  // Configuration registers; the user must write them only while the decoder is idle (not enforced here)
  logic [10:0] frame_columns_r;
  logic [9:0]  origin_x_r;
  logic [9:0]  origin_y_r;

  // Parser to writer hand-off
  logic    q_push, q_pop;
  job_t    push_job, head_job;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_columns_r <= 11'd1;
      origin_x_r      <= '0;
      origin_y_r      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_COLUMNS: frame_columns_r <= cfg_data;
        CFG_ORIGIN_X:      origin_x_r      <= cfg_data[9:0];
        CFG_ORIGIN_Y:      origin_y_r      <= cfg_data[9:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Front: takes one byte per cycle while the queue has room, updates the
  // parse state in that cycle and posts a job for every byte with results.
  crsd_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .frame_columns (frame_columns_r),
    .origin_x      (origin_x_r),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  crsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // Back: loads a job, then issues one beat per cycle into the output
  // register while out_stall is low; a job ends with the frame-end beat when flagged.
  crsd_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .origin_y  (origin_y_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The parser never posts into a full queue
  `CRSD_ASSERT_IMP(a_no_push_full, q_stat.full, !q_push, "job pushed into full queue")
  // Within one byte's results the writer has the next beat ready right away
  `CRSD_ASSERT_NXT(a_run_contiguous, out_valid && !out_stall && !out_data.last, out_valid,
    "gap inside the results of one byte")

endmodule
